@@ src/bca_pkg.sv @@
// Package for the bias current averager.
// Holds the widths, constants and transfer struct types that the divider, top level and testbench share.
// It has no dependencies.
package bca_pkg;

   localparam int WINDOW_DEPTH = 40;
   localparam int PRIME_DELAY  = 2;

   localparam int READ_W  = 16;
   localparam int CUR_W   = 19;
   localparam int CNT_W   = 4;
   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int SUM_W   = READ_W + $clog2(WINDOW_DEPTH);
   localparam int PROD_W  = SUM_W + 4;

   localparam int RECIP_SHIFT = PROD_W + $clog2(WINDOW_DEPTH);
   localparam int RECIP_W     = PROD_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));

   localparam logic [READ_W-1:0] INVALID_WORD   = 16'h006B;
   localparam logic [READ_W-1:0] NEG_FULL_WORD  = 16'h8000;
   localparam logic [READ_W-1:0] LIMIT_RESET    = 16'd32000;
   localparam logic [CNT_W-1:0]  PRIME_RELOAD   = CNT_W'(PRIME_DELAY);
   localparam logic [PTR_W-1:0]  LAST_ENTRY     = PTR_W'(WINDOW_DEPTH - 1);

   typedef struct packed {
      logic              read_ok;
      logic [READ_W-1:0] sample_word;
      logic              tx_active;
   } req_type;

   typedef struct packed {
      logic [CUR_W-1:0] bias_current;
      logic             priming;
   } rsp_type;

endpackage

@@ src/bca_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the averaging window; it has no dependencies.
module bca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/bca_div.sv @@
// Divider by the constant window depth, done as a reciprocal multiplication
// with a registered product; the quotient and done are valid in the cycle after start.
// Depends on bca_pkg for the dividend width and the reciprocal constants.
module bca_div
   import bca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   output logic [PROD_W-1:0] quotient,
   output logic              done
);

   logic [PROD_W+RECIP_W-1:0] prod_ff, prod_in;
   logic                      done_ff, done_in;

   always_comb begin
      prod_in = start ? (PROD_W+RECIP_W)'(dividend) * (PROD_W+RECIP_W)'(RECIP_MULT) : prod_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign quotient = PROD_W'(prod_ff >> RECIP_SHIFT);
   assign done     = done_ff;

endmodule

@@ src/bias_current_averager_top.sv @@
// Top level of the bias current averager: control sequencer, window RAM and divider.
// Depends on bca_pkg, bca_ram and bca_div.
//
// One sensor read is taken at a time. A read that is rejected, restarts the window
// or counts down the priming passes from the evaluate state straight to the output
// state. A read that updates the moving average passes through the evaluate, RAM
// read, update, divider start, divider wait and output states: the oldest entry is
// read from the window RAM, the new one written back, and the divide by the window
// depth is a registered reciprocal multiply. The read that ends the priming fills the
// window, one entry per cycle for all 40 entries, before its output. After reset a
// fill pass clears all 40 RAM entries, taking no read. A result waiting for rsp_ready
// holds the next read in its output state; upper_limit writes are taken at any time.
module bias_current_averager_top
   import bca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [READ_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_FILL, ST_IDLE, ST_EVAL, ST_READ, ST_UPD, ST_DIV_START, ST_DIV_WAIT, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [READ_W-1:0] limit_ff, limit_in;
   logic [READ_W-1:0] last_ff, last_in;
   logic [READ_W-1:0] reading_ff, reading_in;
   logic [READ_W-1:0] fill_val_ff, fill_val_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CUR_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  fcnt_ff, fcnt_in;
   logic              pending_ff, pending_in;
   logic              tx_seen_ff, tx_seen_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [READ_W-1:0] converted;
   logic [READ_W-1:0] reading;
   logic [READ_W+3:0] reading_x10;
   logic [CNT_W-1:0]  count_dec;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [READ_W-1:0] wr_data;
   logic [READ_W-1:0] rd_data;
   logic              div_start;
   logic              div_done;
   logic [PROD_W-1:0] div_quot;
   logic [PROD_W-1:0] dividend;

   bca_ram #(.WIDTH(READ_W), .DEPTH(WINDOW_DEPTH)) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign dividend = (PROD_W'(sum_ff) << 3) + (PROD_W'(sum_ff) << 1);

   bca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      converted   = (item_ff.sample_word[READ_W-1] && item_ff.sample_word != NEG_FULL_WORD) ?
                    '0 : item_ff.sample_word;
      reading     = (item_ff.sample_word != INVALID_WORD) ? converted : last_ff;
      reading_x10 = ((READ_W+4)'(reading) << 3) + ((READ_W+4)'(reading) << 1);
      count_dec   = count_ff - 1'b1;

      state_in     = state_ff;
      item_in      = item_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      last_in      = last_ff;
      reading_in   = reading_ff;
      fill_val_in  = fill_val_ff;
      sum_in       = sum_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      fcnt_in      = fcnt_ff;
      pending_in   = pending_ff;
      tx_seen_in   = tx_seen_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = reading_ff;
      div_start    = 1'b0;

      case (state_ff)
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = fcnt_ff;
            wr_data = fill_val_ff;
            sum_in  = sum_ff + SUM_W'(fill_val_ff);
            if (fcnt_ff == LAST_ENTRY) begin
               fcnt_in  = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_OUT;
            end else begin
               fcnt_in = fcnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            tx_seen_in = item_ff.tx_active;
            state_in   = ST_OUT;
            if (item_ff.read_ok) begin
               last_in    = reading;
               reading_in = reading;
               if (reading < limit_ff) begin
                  if (item_ff.tx_active != tx_seen_ff) begin
                     sum_in     = '0;
                     pending_in = 1'b1;
                     held_in    = '0;
                  end else if (pending_ff) begin
                     if (count_dec == '0) begin
                        fill_val_in = reading;
                        sum_in      = '0;
                        held_in     = reading_x10[CUR_W-1:0];
                        count_in    = PRIME_RELOAD;
                        pending_in  = 1'b0;
                        state_in    = ST_FILL;
                     end else begin
                        count_in = count_dec;
                        held_in  = '0;
                     end
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            wr_en    = 1'b1;
            sum_in   = sum_ff - SUM_W'(rd_data) + SUM_W'(reading_ff);
            ptr_in   = (ptr_ff == LAST_ENTRY) ? '0 : ptr_ff + 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               held_in  = div_quot[CUR_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.bias_current = held_ff;
               rsp_data_in.priming      = pending_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      reading_ff  <= reading_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         limit_ff     <= LIMIT_RESET;
         last_ff      <= '0;
         fill_val_ff  <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
         count_ff     <= PRIME_RELOAD;
         ptr_ff       <= '0;
         fcnt_ff      <= '0;
         pending_ff   <= 1'b0;
         tx_seen_ff   <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         last_ff      <= last_in;
         fill_val_ff  <= fill_val_in;
         sum_ff       <= sum_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         fcnt_ff      <= fcnt_in;
         pending_ff   <= pending_in;
         tx_seen_ff   <= tx_seen_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The current is forced to zero for as long as the window is priming.
   a_priming_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.priming |-> rsp_data.bias_current == '0)
      else $error("nonzero current reported while priming");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_fill_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FILL |-> fcnt_ff == '0)
      else $error("fill counter left running outside the fill pass");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the bias current averager top level.
// Depends on bca_pkg and bias_current_averager_top; a local predictor
// checks every result transfer against the expected averaged current and priming flag.
module tb_top;
   import bca_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int SQUEEZE_AT  = 400;
   localparam int SQUEEZE_LEN = 600;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [READ_W-1:0] csr_wr_data = '0;

   bias_current_averager_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   req_type reads_to_send [$];
   rsp_type expected_currents [$];

   logic [READ_W-1:0] taps [WINDOW_DEPTH];
   int unsigned       tap_sum;
   logic [READ_W-1:0] last_reading;
   logic [READ_W-1:0] limit_now;
   logic              prime_wait;
   logic [CNT_W-1:0]  prime_count;
   logic              tx_last;
   logic [CUR_W-1:0]  held_current;

   int   queued_reads   = 0;
   int   taken_reads    = 0;
   int   taken_results  = 0;
   int   errors         = 0;
   int   idle_cycles    = 0;
   int   send_gap       = 0;
   int   stall_left     = 0;
   int   level          = 0;
   bit   no_idle        = 1'b0;
   bit   squeezed       = 1'b0;
   logic req_taken      = 1'b0;
   logic tx_state       = 1'b0;

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (no_idle) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic rsp_type average_read(req_type item);
      logic change;
      rsp_type res;
      change = (item.tx_active != tx_last);
      tx_last = item.tx_active;
      if (item.read_ok) begin
         if (item.sample_word != INVALID_WORD) begin
            if (!item.sample_word[READ_W-1] || item.sample_word == NEG_FULL_WORD) begin
               last_reading = item.sample_word;
            end else begin
               last_reading = '0;
            end
         end
         if (last_reading < limit_now) begin
            if (change) begin
               foreach (taps[i]) taps[i] = '0;
               tap_sum      = 0;
               prime_wait   = 1'b1;
               held_current = '0;
            end else if (prime_wait) begin
               prime_count = prime_count - 1'b1;
               if (prime_count == '0) begin
                  foreach (taps[i]) taps[i] = last_reading;
                  tap_sum      = last_reading * WINDOW_DEPTH;
                  held_current = CUR_W'(last_reading * 10);
                  prime_count  = PRIME_RELOAD;
                  prime_wait   = 1'b0;
               end else begin
                  held_current = '0;
               end
            end else begin
               tap_sum = tap_sum - taps[WINDOW_DEPTH-1] + last_reading;
               for (int i = WINDOW_DEPTH - 1; i > 0; i--) taps[i] = taps[i-1];
               taps[0]      = last_reading;
               held_current = CUR_W'((tap_sum * 10) / WINDOW_DEPTH);
            end
         end
      end
      res.bias_current = held_current;
      res.priming      = prime_wait;
      return res;
   endfunction

   function automatic req_type make_random_read(int lim);
      req_type item;
      int pick;
      int lo;
      int hi;
      if ($urandom_range(0, 99) < 3) begin
         tx_state = ~tx_state;
      end
      item.read_ok   = ($urandom_range(0, 99) >= 6);
      item.tx_active = tx_state;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         item.sample_word = INVALID_WORD;
      end else if (pick < 7) begin
         item.sample_word = NEG_FULL_WORD;
      end else if (pick < 17) begin
         item.sample_word = {1'b1, 15'($urandom)};
      end else if (pick < 30) begin
         lo = (lim > 4) ? lim - 4 : 0;
         hi = (lim + 4 > 32767) ? 32767 : lim + 4;
         item.sample_word = READ_W'($urandom_range(hi, lo));
      end else if (pick < 60) begin
         lo = (level > 50) ? level - 50 : 0;
         hi = (level + 50 > 32767) ? 32767 : level + 50;
         item.sample_word = READ_W'($urandom_range(hi, lo));
      end else begin
         item.sample_word = READ_W'($urandom_range(32767, 0));
      end
      return item;
   endfunction

   task automatic add_read(input logic ok, input logic [READ_W-1:0] word, input logic tx);
      req_type item;
      item.read_ok     = ok;
      item.sample_word = word;
      item.tx_active   = tx;
      reads_to_send.push_back(item);
      queued_reads++;
   endtask

   task automatic wait_drained();
      while (taken_reads != queued_reads || expected_currents.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input logic [READ_W-1:0] limit, input int count, input bit calm);
      int ceiling;
      wait_drained();
      repeat (8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_now = limit;
      ceiling = (limit == 0) ? 0 : int'(limit) - 1;
      if (ceiling > 32767) begin
         ceiling = 32767;
      end
      @(posedge clock);
      no_idle = calm;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            level = $urandom_range(ceiling, 0);
         end
         reads_to_send.push_back(make_random_read(int'(limit)));
         queued_reads++;
      end
   endtask

   // Sender: a new read is offered only after the previous transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (reads_to_send.size() > 0) begin
            req_data  <= reads_to_send.pop_front();
            req_valid <= 1'b1;
            send_gap  <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   always @(negedge clock) begin
      int gap;
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!squeezed && taken_results >= SQUEEZE_AT) begin
         squeezed   <= 1'b1;
         rsp_ready  <= 1'b0;
         stall_left <= SQUEEZE_LEN;
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= gap - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type oldest;
      req_taken <= req_valid && req_ready;
      if (req_valid && req_ready) begin
         expected_currents.push_back(average_read(req_data));
         taken_reads <= taken_reads + 1;
      end
      if (rsp_valid && rsp_ready) begin
         taken_results <= taken_results + 1;
         if (expected_currents.size() == 0) begin
            errors++;
            $display("%0t: result transfer with none expected, bias_current %0d priming %0b",
                     $time, rsp_data.bias_current, rsp_data.priming);
         end else begin
            oldest = expected_currents.pop_front();
            if (rsp_data.bias_current !== oldest.bias_current) begin
               errors++;
               $display("%0t: bias_current expected %0d actual %0d",
                        $time, oldest.bias_current, rsp_data.bias_current);
            end
            if (rsp_data.priming !== oldest.priming) begin
               errors++;
               $display("%0t: priming expected %0b actual %0b",
                        $time, oldest.priming, rsp_data.priming);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      foreach (taps[i]) taps[i] = '0;
      tap_sum      = 0;
      last_reading = '0;
      limit_now    = LIMIT_RESET;
      prime_wait   = 1'b0;
      prime_count  = PRIME_RELOAD;
      tx_last      = 1'b0;
      held_current = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The reset limit is checked first, at the boundary and around it.
      add_read(1'b1, 16'd0, 1'b0);
      add_read(1'b1, 16'h7FFF, 1'b0);
      add_read(1'b1, INVALID_WORD, 1'b0);
      add_read(1'b1, NEG_FULL_WORD, 1'b0);
      add_read(1'b1, 16'hFFFF, 1'b0);
      add_read(1'b1, 16'd31999, 1'b0);
      add_read(1'b1, 16'h7D00, 1'b0);
      add_read(1'b1, 16'd100, 1'b1);
      add_read(1'b0, 16'd5, 1'b1);
      add_read(1'b1, 16'd200, 1'b1);
      add_read(1'b1, INVALID_WORD, 1'b1);
      add_read(1'b1, 16'd31999, 1'b1);
      add_read(1'b0, 16'h1234, 1'b0);
      add_read(1'b1, 16'd1, 1'b0);
      add_read(1'b1, 16'h7D00, 1'b1);
      add_read(1'b1, 16'h5555, 1'b0);
      add_read(1'b1, 16'h2AAA, 1'b0);
      add_read(1'b1, 16'hAAAA, 1'b0);
      add_read(1'b1, 16'h7CFF, 1'b0);
      add_read(1'b0, 16'hFFFF, 1'b1);
      run_phase(NEG_FULL_WORD, 880, 1'b0);
      run_phase(16'd0, 60, 1'b0);
      run_phase(16'd1, 60, 1'b1);
      run_phase(16'h0100, 150, 1'b0);
      run_phase(READ_W'($urandom_range(32767, 2)), 300, 1'b1);
      run_phase(LIMIT_RESET, 480, 1'b0);
      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
